// File: sv/rgb_to_hls_convert_core_assert.svh
// ----------------------------------------------------------------------------
// RGB to HLS converter assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HLS_CONVERT_CORE_ASSERT_SVH
`define RGB_TO_HLS_CONVERT_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define HLSC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hlsc: same-cycle implication violated");
// Next-cycle implication, disabled during reset
`define HLSC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hlsc: next-cycle implication violated");
`else
`define HLSC_ASSERT_IMP(name, clk, rstn, ante, cons)
`define HLSC_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// File: sv/hlsc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HLS converter package
// Payload types, pipeline stage types and fixed constants.
// ----------------------------------------------------------------------------
package hlsc_pkg;

  localparam int unsigned ChanW  = 8;   // one color channel
  localparam int unsigned SumW   = 9;   // max + min
  localparam int unsigned QuotW  = 16;  // hue and saturation quotients
  localparam int unsigned NumW   = 24;  // divider dividend
  localparam int unsigned TermW  = 11;  // k*diff + x - y

  localparam logic [QuotW-1:0] HueFullTurn = 16'd46080;
  localparam logic [NumW-1:0]  HueSector   = 24'd7680;
  localparam logic [SumW-1:0]  SumHalf     = 9'd255;
  localparam logic [SumW-1:0]  SumFull     = 9'd510;

  // Sector offsets by maximum channel
  localparam logic [TermW-1:0] KRed   = 11'd6;
  localparam logic [TermW-1:0] KGreen = 11'd2;
  localparam logic [TermW-1:0] KBlue  = 11'd4;

  typedef enum logic [2:0] {
    MaxRed   = 3'b001,
    MaxGreen = 3'b010,
    MaxBlue  = 3'b100
  } hlsc_max_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } hlsc_pixel_t;

  typedef struct packed {
    logic [QuotW-1:0] hue_angle;
    logic [SumW-1:0]  lightness_sum;
    logic [QuotW-1:0] saturation_level;
  } hlsc_hls_t;

  // After max/min search
  typedef struct packed {
    logic [ChanW-1:0]        diff;
    logic [SumW-1:0]         sum;
    logic [ChanW-1:0]        den;
    logic signed [ChanW:0]   xmy;
    hlsc_max_e               sel;
  } hlsc_front_t;

  // Divider operands
  typedef struct packed {
    logic [NumW-1:0]  hue_num;
    logic [NumW-1:0]  sat_num;
    logic [ChanW-1:0] diff;
    logic [ChanW-1:0] den;
    logic [SumW-1:0]  sum;
  } hlsc_num_t;

  // Fields that ride alongside the dividers
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            gray;
  } hlsc_side_t;

endpackage

// File: sv/rgb_to_hls_convert_core.sv
// ----------------------------------------------------------------------------
// RGB to HLS converter core
// Streams 8-bit RGB pixels to fixed-point hue, lightness and saturation.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless stalled (in_ready_o low) and returns one
// result per pixel, in order. Depth is set by the two restoring dividers
// (hue and saturation) that retire RADIX_BITS quotient bits per pipeline
// stage. Every stage holds its own valid bit and advances whenever the stage
// after it is empty or moving, so bubbles close up and a stalled output does
// not block input until the pipeline is full.
// hue_angle is in 1/128 degree (0..46080), lightness_sum is max+min
// (lightness = value/510), saturation_level is saturation*65535 truncated;
// gray pixels give hue 0 and saturation 0.
`include "rgb_to_hls_convert_core_assert.svh"

module rgb_to_hls_convert_core #(
  parameter int unsigned RADIX_BITS = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hlsc_pkg::hlsc_pixel_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hlsc_pkg::hlsc_hls_t   out_data_o
);
  import hlsc_pkg::*;

  localparam int unsigned DivStages = QuotW / RADIX_BITS;
  localparam int unsigned NStg      = DivStages + 3;
  localparam int unsigned DivFirst  = 2;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  // Stage advances when empty or when its successor advances
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int i = NStg - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  // Move valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NStg; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  hlsc_front_t      front_d, front_q;
  logic [ChanW-1:0] mx, mn;

  // Find max and min, pick the hue sector, form the saturation divisor
  always_comb begin
    mx = in_data_i.red;
    mn = in_data_i.red;
    if (in_data_i.green > mx) mx = in_data_i.green;
    if (in_data_i.blue > mx)  mx = in_data_i.blue;
    if (in_data_i.green < mn) mn = in_data_i.green;
    if (in_data_i.blue < mn)  mn = in_data_i.blue;

    front_d.diff = mx - mn;
    front_d.sum  = {1'b0, mx} + {1'b0, mn};
    if (front_d.sum < SumHalf) begin
      front_d.den = front_d.sum[ChanW-1:0];
    end else begin
      front_d.den = ChanW'(SumFull - front_d.sum);
    end

    priority if (in_data_i.red == mx) begin
      front_d.sel = MaxRed;
      front_d.xmy = $signed({1'b0, in_data_i.green}) - $signed({1'b0, in_data_i.blue});
    end else if (in_data_i.green == mx) begin
      front_d.sel = MaxGreen;
      front_d.xmy = $signed({1'b0, in_data_i.blue}) - $signed({1'b0, in_data_i.red});
    end else begin
      front_d.sel = MaxBlue;
      front_d.xmy = $signed({1'b0, in_data_i.red}) - $signed({1'b0, in_data_i.green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      front_q <= front_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  hlsc_num_t        num_d, num_q;
  logic [TermW-1:0] kd;
  logic [TermW:0]   term;

  // Build hue and saturation dividends
  always_comb begin
    unique case (front_q.sel)
      MaxRed:   kd = TermW'(front_q.diff) * KRed;
      MaxGreen: kd = TermW'(front_q.diff) * KGreen;
      MaxBlue:  kd = TermW'(front_q.diff) * KBlue;
      default:  kd = '0;
    endcase
    term = {1'b0, kd} + {{(TermW-ChanW){front_q.xmy[ChanW]}}, front_q.xmy};

    num_d.hue_num = NumW'(term[TermW-1:0]) * HueSector;
    num_d.sat_num = (NumW'(front_q.diff) << QuotW) - NumW'(front_q.diff);
    num_d.diff    = front_q.diff;
    num_d.den     = front_q.den;
    num_d.sum     = front_q.sum;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      num_q <= num_d;
    end
  end

  // ------------------------------------------------------------ divider stages
  logic [QuotW-1:0] hue_quot, sat_quot;

  hlsc_div #(
    .StepBits (RADIX_BITS)
  ) u_hue_div (
    .clk_i      (clk_i),
    .load_i     (en[DivFirst +: DivStages]),
    .dividend_i (num_q.hue_num),
    .divisor_i  (num_q.diff),
    .quotient_o (hue_quot)
  );

  hlsc_div #(
    .StepBits (RADIX_BITS)
  ) u_sat_div (
    .clk_i      (clk_i),
    .load_i     (en[DivFirst +: DivStages]),
    .dividend_i (num_q.sat_num),
    .divisor_i  (num_q.den),
    .quotient_o (sat_quot)
  );

  // Carry lightness and gray flag alongside the dividers
  hlsc_side_t side_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[DivFirst]) begin
          side_q[s].sum  <= num_q.sum;
          side_q[s].gray <= (num_q.diff == '0);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[DivFirst + s]) begin
          side_q[s] <= side_q[s-1];
        end
      end
    end
  end

  // ---------------------------------------------------------- output stage
  hlsc_hls_t out_d, out_q;

  // Wrap hue past a full turn, zero gray pixels
  always_comb begin
    out_d.lightness_sum = side_q[DivStages-1].sum;
    if (side_q[DivStages-1].gray) begin
      out_d.hue_angle        = '0;
      out_d.saturation_level = '0;
    end else begin
      out_d.saturation_level = sat_quot;
      if (hue_quot > HueFullTurn) begin
        out_d.hue_angle = hue_quot - HueFullTurn;
      end else begin
        out_d.hue_angle = hue_quot;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NStg-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NStg-1];
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- checks
  `HLSC_ASSERT_NXT(a_entry_captured, clk_i, rst_ni, in_valid_i && in_ready_o, v_q[0])
  `HLSC_ASSERT_IMP(a_hue_in_range, clk_i, rst_ni, out_valid_o, out_data_o.hue_angle <= HueFullTurn)
  `HLSC_ASSERT_IMP(a_light_in_range, clk_i, rst_ni, out_valid_o, out_data_o.lightness_sum <= SumFull)
  `HLSC_ASSERT_IMP(a_gray_hue_zero, clk_i, rst_ni, out_valid_o && (out_data_o.saturation_level == '0), out_data_o.hue_angle == '0)

endmodule

// File: sv/hlsc_div.sv
// ----------------------------------------------------------------------------
// RGB to HLS converter divider
// Pipelined restoring divider: 24-bit dividend, 8-bit divisor, 16-bit
// quotient, StepBits quotient bits per register stage. The dividend's top
// byte must be below the divisor.
// ----------------------------------------------------------------------------
module hlsc_div #(
  parameter int unsigned  StepBits = 2,
  localparam int unsigned Stages   = hlsc_pkg::QuotW / StepBits
) (
  input  logic                        clk_i,
  input  logic [Stages-1:0]           load_i,
  input  logic [hlsc_pkg::NumW-1:0]   dividend_i,
  input  logic [hlsc_pkg::ChanW-1:0]  divisor_i,
  output logic [hlsc_pkg::QuotW-1:0]  quotient_o
);
  import hlsc_pkg::*;

  // Partial remainder, remaining dividend bits with quotient shifted in, divisor
  logic [ChanW-1:0] rem_q  [Stages];
  logic [QuotW-1:0] work_q [Stages];
  logic [ChanW-1:0] dvs_q  [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [ChanW-1:0] rem_in;
    logic [QuotW-1:0] work_in;
    logic [ChanW-1:0] dvs_in;
    logic [ChanW-1:0] rem_d;
    logic [QuotW-1:0] work_d;

    if (s == 0) begin : g_first
      assign rem_in  = dividend_i[NumW-1 -: ChanW];
      assign work_in = dividend_i[QuotW-1:0];
      assign dvs_in  = divisor_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign dvs_in  = dvs_q[s-1];
    end

    // Retire StepBits quotient bits
    always_comb begin : step
      logic [ChanW:0] trial;
      rem_d  = rem_in;
      work_d = work_in;
      trial  = '0;
      for (int j = 0; j < StepBits; j++) begin
        trial  = {rem_d, work_d[QuotW-1]};
        work_d = {work_d[QuotW-2:0], 1'b0};
        if (trial >= {1'b0, dvs_in}) begin
          trial     = trial - {1'b0, dvs_in};
          work_d[0] = 1'b1;
        end
        rem_d = trial[ChanW-1:0];
      end
    end

    // Advance stage
    always_ff @(posedge clk_i) begin
      if (load_i[s]) begin
        rem_q[s]  <= rem_d;
        work_q[s] <= work_d;
        dvs_q[s]  <= dvs_in;
      end
    end
  end

  assign quotient_o = work_q[Stages-1];

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// RGB to HLS converter testbench
// Streams directed and random pixels through the core with random idling and
// back-pressure, and checks every hue, lightness and saturation result
// against an integer model of the conversion, in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hlsc_pkg::*;

  localparam int unsigned StallLimit  = 2000;  // cycles without any transaction
  localparam int unsigned HoldCycles  = 80;    // long receiver hold-off
  localparam int unsigned DrainCycles = 24;    // wait for stray results after draining
  localparam int unsigned NumRandom   = 600;

  // Expected results of accepted pixels, oldest first
  class hls_result_tracker;
    localparam int SatScale = 65535;

    hlsc_hls_t   pending_hls[$];
    int unsigned mismatch_cnt;
    int unsigned checked_cnt;
    int unsigned gray_cnt;
    int unsigned wrap_cnt;
    int unsigned full_turn_cnt;
    int unsigned max_red_cnt;
    int unsigned max_green_cnt;
    int unsigned max_blue_cnt;

    // Compute hue, lightness and saturation of one pixel
    function hlsc_hls_t predict_hls(hlsc_pixel_t px);
      int        r, g, b, mx, mn, diff, sum, den, sat, hue, k, x, y;
      hlsc_max_e sel;
      hlsc_hls_t res;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff = mx - mn;
      sum  = mx + mn;
      hue  = 0;
      sat  = 0;
      if (diff == 0) begin
        gray_cnt++;
      end else begin
        den = (sum < int'(SumHalf)) ? sum : int'(SumFull) - sum;
        sat = diff * SatScale / den;
        if (sat > SatScale) sat = SatScale;
        // Maximum channel picks the sector, red first, then green
        if (r == mx) sel = MaxRed;
        else if (g == mx) sel = MaxGreen;
        else sel = MaxBlue;
        case (sel)
          MaxRed: begin
            k = int'(KRed); x = g; y = b; max_red_cnt++;
          end
          MaxGreen: begin
            k = int'(KGreen); x = b; y = r; max_green_cnt++;
          end
          default: begin
            k = int'(KBlue); x = r; y = g; max_blue_cnt++;
          end
        endcase
        hue = int'(HueSector) * (k * diff + x - y) / diff;
        // Fold past a full turn; exactly 360 degrees stays
        if (hue > int'(HueFullTurn)) begin
          hue -= int'(HueFullTurn);
          wrap_cnt++;
        end else if (hue == int'(HueFullTurn)) begin
          full_turn_cnt++;
        end
      end
      res.hue_angle        = QuotW'(hue);
      res.lightness_sum    = SumW'(sum);
      res.saturation_level = QuotW'(sat);
      return res;
    endfunction

    function void note_pixel(hlsc_pixel_t px);
      pending_hls.push_back(predict_hls(px));
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_cnt++;
      if (mismatch_cnt <= 40)
        $display("%0t mismatch: %s got %0d expected %0d (result %0d)",
                 $realtime, what, got, want, checked_cnt);
    endtask

    // Compare one result with the oldest expectation
    task check_hls(hlsc_hls_t got);
      hlsc_hls_t want;
      if (pending_hls.size() == 0) begin
        report_mismatch("unexpected result, hue", got.hue_angle, 0);
      end else begin
        want = pending_hls.pop_front();
        if (got.hue_angle != want.hue_angle)
          report_mismatch("hue_angle", got.hue_angle, want.hue_angle);
        if (got.lightness_sum != want.lightness_sum)
          report_mismatch("lightness_sum", got.lightness_sum, want.lightness_sum);
        if (got.saturation_level != want.saturation_level)
          report_mismatch("saturation_level", got.saturation_level,
                          want.saturation_level);
      end
      checked_cnt++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n_q = 1'b0;
  logic        in_valid_q = 1'b0;
  hlsc_pixel_t in_data_q = '0;
  logic        out_ready_q = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  hlsc_hls_t   out_data_o;

  hls_result_tracker tracker = new();

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned pixels_in = 0;
  int unsigned input_stall_cnt = 0;
  int unsigned quiet_cycles = 0;

  rgb_to_hls_convert_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .out_data_o  (out_data_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Record accepted pixels and check accepted results
  always @(posedge clk_i) begin
    if (rst_n_q) begin
      if (in_valid_q && in_ready_o) begin
        tracker.note_pixel(in_data_q);
        pixels_in++;
      end
      if (in_valid_q && !in_ready_o) input_stall_cnt++;
      if (out_valid_o && out_ready_q) tracker.check_hls(out_data_o);
    end
  end

  // Watchdog: end the run when no transaction happens for too long
  always @(posedge clk_i) begin
    if (rst_n_q) begin
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("watchdog: no transaction for %0d cycles, %0d results pending",
                   quiet_cycles, tracker.pending_hls.size());
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready_q <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_ready_q <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ready_q <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic hlsc_pixel_t pix(int r, int g, int b);
    return {ChanW'(r), ChanW'(g), ChanW'(b)};
  endfunction

  // Mix of uniform, gray, tied-maximum, extreme and near-gray pixels
  function automatic hlsc_pixel_t rand_pixel();
    int v;
    hlsc_pixel_t px;
    px = pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    v  = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      6: px = pix(v, v, v);
      7: begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue = px.green;
          default: px.blue = px.red;
        endcase
      end
      8: px = pix($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                  $urandom_range(0, 1) * 255);
      9: px = pix(v, (v + $urandom_range(0, 2)) % 256, (v + 255 * $urandom_range(0, 1)) % 256);
      default: ;
    endcase
    return px;
  endfunction

  // Offer one pixel and hold it until the core takes it
  task automatic send_pixel(hlsc_pixel_t px);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    in_data_q  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin
    hlsc_pixel_t directed[$];

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    rst_n_q <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, gray, primaries, tied maxima, hue wrap,
    // exactly 360 degrees, full saturation and the lightness midpoint
    directed = '{pix(0, 0, 0), pix(255, 255, 255), pix(128, 128, 128),
                 pix(255, 0, 0), pix(0, 255, 0), pix(0, 0, 255),
                 pix(255, 255, 0), pix(0, 255, 255), pix(255, 0, 255),
                 pix(255, 1, 0), pix(1, 0, 0), pix(0, 0, 1),
                 pix(254, 0, 0), pix(255, 0, 1), pix(255, 1, 1),
                 pix(255, 254, 254), pix(1, 1, 0), pix(0, 1, 1),
                 pix(128, 127, 127), pix(127, 128, 128), pix(10, 200, 100),
                 pix(30, 60, 220), pix(200, 150, 10), pix(255, 255, 254)};
    foreach (directed[i]) send_pixel(directed[i]);

    // Random with idling on both sides; one long receiver hold-off
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 150) begin
        hold_req = 1'b1;
        tx_idle  = 1'b0;
      end
      if (i == 200) tx_idle = 1'b1;
      // Last part runs with no idling at all
      if (i == NumRandom - 150) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      send_pixel(rand_pixel());
    end
    in_valid_q <= 1'b0;

    // Drain, then allow the pipeline latency for any stray result
    while (tracker.pending_hls.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("coverage: %0d pixels, %0d results, %0d gray, %0d hue wraps, %0d at 360 deg",
             pixels_in, tracker.checked_cnt, tracker.gray_cnt, tracker.wrap_cnt,
             tracker.full_turn_cnt);
    $display("coverage: max red/green/blue %0d/%0d/%0d, %0d input stall cycles",
             tracker.max_red_cnt, tracker.max_green_cnt, tracker.max_blue_cnt,
             input_stall_cnt);
    if (tracker.mismatch_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
